// File: hw/rtl/v3a_pkg.sv
// Shared opcodes, beat types and the Q16.16 saturation helper for the vector ALU.
`default_nettype none

package v3a_pkg;

    localparam logic [3:0] OP_ADD       = 4'd0;
    localparam logic [3:0] OP_SUB       = 4'd1;
    localparam logic [3:0] OP_SCALE     = 4'd2;
    localparam logic [3:0] OP_DOT       = 4'd3;
    localparam logic [3:0] OP_LENGTH    = 4'd4;
    localparam logic [3:0] OP_NORMALIZE = 4'd5;
    localparam logic [3:0] OP_CROSS     = 4'd6;
    localparam logic [3:0] OP_LERP      = 4'd7;
    localparam logic [3:0] OP_REFLECT   = 4'd8;

    // width of a rounded Q16.16 value before it is clamped
    localparam int RND_W = 72;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic               saturated;
        logic               zero_length;
    } out_beat_t;

    // what the front end hands to the root and divide stages
    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] res;
        logic             sat;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [4:0]       k;
        logic             zero;
    } side_t;

    // {clamped, value}
    function automatic logic [32:0] sat_q32(input logic signed [RND_W-1:0] v);
        logic fits;
        fits = (&v[RND_W-1:31]) | ~(|v[RND_W-1:31]);
        if (fits)
        begin
            sat_q32 = {1'b0, v[31:0]};
        end
        else if (v[RND_W-1])
        begin
            sat_q32 = {1'b1, Q_MIN};
        end
        else
        begin
            sat_q32 = {1'b1, Q_MAX};
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/v3a_in_if.sv
// Operand channel: valid/ready handshake carrying one opcode and operand set.
`default_nettype none

interface v3a_in_if;
    logic              valid;
    logic              ready;
    v3a_pkg::in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/v3a_out_if.sv
// Result channel: valid/ready handshake carrying one result vector and flags.
`default_nettype none

interface v3a_out_if;
    logic               valid;
    logic               ready;
    v3a_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/v3a_arith.sv
// Front end: operand select, products, sums, rounding, reflect and clamp stages.
`default_nettype none

module v3a_arith (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  v3a_pkg::in_beat_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output v3a_pkg::side_t    dn_data,
    output logic [63:0]       dn_rad
);

    localparam int NS = 7;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    logic signed [31:0] ia [3];
    logic signed [31:0] ib [3];
    logic signed [32:0] ma_next [6];
    logic signed [32:0] mb_next [6];

    logic [3:0]         op1_reg;
    logic signed [31:0] a1_reg [3];
    logic signed [31:0] b1_reg [3];
    logic signed [32:0] ma1_reg [6];
    logic signed [32:0] mb1_reg [6];

    logic [3:0]         op2_reg;
    logic signed [31:0] a2_reg [3];
    logic signed [31:0] b2_reg [3];
    logic signed [65:0] p2_reg [6];

    logic [3:0]         op3_reg;
    logic signed [31:0] a3_reg [3];
    logic signed [31:0] b3_reg [3];
    logic signed [67:0] acc3_next [3];
    logic signed [67:0] acc3_reg [3];

    logic [3:0]         op4_reg;
    logic signed [31:0] a4_reg [3];
    logic signed [31:0] b4_reg [3];
    logic signed [67:0] sum4 [3];
    logic signed [51:0] rnd4_reg [3];
    logic [63:0]        s4_reg;
    logic [4:0]         lz4_reg [4];

    logic [3:0]         op5_reg;
    logic signed [31:0] a5_reg [3];
    logic signed [51:0] rnd5_reg [3];
    logic [63:0]        s5_reg;
    logic [6:0]         lz_next;
    logic [4:0]         k5_next;
    logic [4:0]         k5_reg;
    logic               zero5_reg;
    logic signed [26:0] dh;
    logic signed [25:0] dl;
    logic signed [58:0] ph5_reg [3];
    logic signed [57:0] pl5_reg [3];

    logic [3:0]         op6_reg;
    logic [4:0]         k6_reg;
    logic               zero6_reg;
    logic signed [87:0] v6_next [3];
    logic signed [87:0] v6_reg [3];
    logic [63:0]        sn6_reg;
    logic [31:0]        mag6_reg [3];
    logic [2:0]         neg6_reg;

    logic signed [87:0] sum7 [3];
    logic [32:0]        sr7 [3];
    v3a_pkg::side_t     side_next;
    v3a_pkg::side_t     side_reg;
    logic [63:0]        sn7_reg;

    function automatic logic [4:0] lz16(input logic [15:0] x);
        logic [4:0] n;
        n = 5'd16;
        for (int i = 0; i < 16; i++)
        begin
            if (x[i])
            begin
                n = 5'(15 - i);
            end
        end
        return n;
    endfunction

    // a stage may load when it is empty or its successor moves on
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || dn_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign up_ready = en[0];
    assign dn_valid = valid_reg[NS-1];
    assign dn_data  = side_reg;
    assign dn_rad   = sn7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= up_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign ia[0] = up_data.a_x;
    assign ia[1] = up_data.a_y;
    assign ia[2] = up_data.a_z;
    assign ib[0] = up_data.b_x;
    assign ib[1] = up_data.b_y;
    assign ib[2] = up_data.b_z;

    // stage 1: pick multiplier operands per opcode
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ma_next[i] = '0;
            mb_next[i] = '0;
        end
        unique case (up_data.op)
            v3a_pkg::OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i] = 33'(ia[i]);
                    mb_next[i] = 33'(up_data.scale);
                end
            end
            v3a_pkg::OP_DOT, v3a_pkg::OP_REFLECT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i] = 33'(ia[i]);
                    mb_next[i] = 33'(ib[i]);
                end
            end
            v3a_pkg::OP_LENGTH, v3a_pkg::OP_NORMALIZE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i] = 33'(ia[i]);
                    mb_next[i] = 33'(ia[i]);
                end
            end
            v3a_pkg::OP_CROSS:
            begin
                ma_next[0] = 33'(ia[1]);
                mb_next[0] = 33'(ib[2]);
                ma_next[1] = 33'(ia[2]);
                mb_next[1] = 33'(ib[1]);
                ma_next[2] = 33'(ia[2]);
                mb_next[2] = 33'(ib[0]);
                ma_next[3] = 33'(ia[0]);
                mb_next[3] = 33'(ib[2]);
                ma_next[4] = 33'(ia[0]);
                mb_next[4] = 33'(ib[1]);
                ma_next[5] = 33'(ia[1]);
                mb_next[5] = 33'(ib[0]);
            end
            v3a_pkg::OP_LERP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_next[i] = 33'(ib[i]) - 33'(ia[i]);
                    mb_next[i] = 33'(up_data.scale);
                end
            end
            default:
            begin
            end
        endcase
    end

    // stage 3: exact Q32.32 sums; add and sub are lifted so rounding keeps them
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc3_next[i] = '0;
        end
        unique case (op2_reg)
            v3a_pkg::OP_ADD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc3_next[i] = (68'(a2_reg[i]) + 68'(b2_reg[i])) <<< 16;
                end
            end
            v3a_pkg::OP_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc3_next[i] = (68'(a2_reg[i]) - 68'(b2_reg[i])) <<< 16;
                end
            end
            v3a_pkg::OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc3_next[i] = 68'(p2_reg[i]);
                end
            end
            v3a_pkg::OP_DOT, v3a_pkg::OP_REFLECT, v3a_pkg::OP_LENGTH,
            v3a_pkg::OP_NORMALIZE:
            begin
                acc3_next[0] = 68'(p2_reg[0]) + 68'(p2_reg[1]) + 68'(p2_reg[2]);
            end
            v3a_pkg::OP_CROSS:
            begin
                acc3_next[0] = 68'(p2_reg[0]) - 68'(p2_reg[1]);
                acc3_next[1] = 68'(p2_reg[2]) - 68'(p2_reg[3]);
                acc3_next[2] = 68'(p2_reg[4]) - 68'(p2_reg[5]);
            end
            v3a_pkg::OP_LERP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc3_next[i] = 68'(p2_reg[i]) + (68'(a2_reg[i]) <<< 16);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum4[i] = acc3_reg[i] + 68'sh8000;
        end
    end

    // stage 5: leading zero count of the sum of squares, in 16-bit chunks
    always_comb
    begin
        if (lz4_reg[3] != 5'd16)
        begin
            lz_next = 7'(lz4_reg[3]);
        end
        else if (lz4_reg[2] != 5'd16)
        begin
            lz_next = 7'd16 + 7'(lz4_reg[2]);
        end
        else if (lz4_reg[1] != 5'd16)
        begin
            lz_next = 7'd32 + 7'(lz4_reg[1]);
        end
        else
        begin
            lz_next = 7'd48 + 7'(lz4_reg[0]);
        end
        k5_next = (s4_reg == '0) ? 5'd0 : lz_next[5:1];
    end

    assign dh = $signed(rnd4_reg[0][51:25]);
    assign dl = $signed({1'b0, rnd4_reg[0][24:0]});

    // stage 6: reflect is a*2^16 - 2*d*b in Q32.32; the rest pass their rounded value
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (op5_reg == v3a_pkg::OP_REFLECT)
            begin
                v6_next[i] = (88'(a5_reg[i]) <<< 16)
                    - ((((88'(ph5_reg[i])) <<< 25) + 88'(pl5_reg[i])) <<< 1);
            end
            else
            begin
                v6_next[i] = 88'(rnd5_reg[i]) <<< 16;
            end
        end
    end

    // stage 7: round half up and clamp
    always_comb
    begin
        side_next.op   = op6_reg;
        side_next.neg  = neg6_reg;
        side_next.k    = k6_reg;
        side_next.zero = zero6_reg;
        side_next.sat  = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sum7[i]          = v6_reg[i] + 88'sh8000;
            sr7[i]           = v3a_pkg::sat_q32(sum7[i][87:16]);
            side_next.res[i] = sr7[i][31:0];
            side_next.sat    = side_next.sat | sr7[i][32];
            side_next.mag[i] = mag6_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            op1_reg <= up_data.op;
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= ia[i];
                b1_reg[i] <= ib[i];
            end
            for (int i = 0; i < 6; i++)
            begin
                ma1_reg[i] <= ma_next[i];
                mb1_reg[i] <= mb_next[i];
            end
        end
        if (en[1])
        begin
            op2_reg <= op1_reg;
            for (int i = 0; i < 3; i++)
            begin
                a2_reg[i] <= a1_reg[i];
                b2_reg[i] <= b1_reg[i];
            end
            for (int i = 0; i < 6; i++)
            begin
                p2_reg[i] <= ma1_reg[i] * mb1_reg[i];
            end
        end
        if (en[2])
        begin
            op3_reg <= op2_reg;
            for (int i = 0; i < 3; i++)
            begin
                a3_reg[i]   <= a2_reg[i];
                b3_reg[i]   <= b2_reg[i];
                acc3_reg[i] <= acc3_next[i];
            end
        end
        if (en[3])
        begin
            op4_reg <= op3_reg;
            s4_reg  <= acc3_reg[0][63:0];
            for (int i = 0; i < 3; i++)
            begin
                a4_reg[i]   <= a3_reg[i];
                b4_reg[i]   <= b3_reg[i];
                rnd4_reg[i] <= sum4[i][67:16];
            end
            for (int i = 0; i < 4; i++)
            begin
                lz4_reg[i] <= lz16(acc3_reg[0][16*i +: 16]);
            end
        end
        if (en[4])
        begin
            op5_reg   <= op4_reg;
            s5_reg    <= s4_reg;
            k5_reg    <= k5_next;
            zero5_reg <= (s4_reg == '0);
            for (int i = 0; i < 3; i++)
            begin
                a5_reg[i]   <= a4_reg[i];
                rnd5_reg[i] <= rnd4_reg[i];
                ph5_reg[i]  <= dh * b4_reg[i];
                pl5_reg[i]  <= dl * b4_reg[i];
            end
        end
        if (en[5])
        begin
            op6_reg   <= op5_reg;
            k6_reg    <= k5_reg;
            zero6_reg <= zero5_reg;
            sn6_reg   <= s5_reg << {k5_reg, 1'b0};
            for (int i = 0; i < 3; i++)
            begin
                v6_reg[i]   <= v6_next[i];
                neg6_reg[i] <= a5_reg[i][31];
                mag6_reg[i] <= a5_reg[i][31] ? (~a5_reg[i] + 32'd1) : a5_reg[i];
            end
        end
        if (en[6])
        begin
            side_reg <= side_next;
            sn7_reg  <= sn6_reg;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/v3a_sqrt.sv
// Pipelined integer square root: one root bit per stage, side data carried along.
`default_nettype none

module v3a_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    output logic           up_ready,
    input  v3a_pkg::side_t up_data,
    input  logic [63:0]    up_rad,
    output logic           dn_valid,
    input  logic           dn_ready,
    output v3a_pkg::side_t dn_data,
    output logic [31:0]    dn_root
);

    localparam int NQ = 32;

    typedef struct packed {
        v3a_pkg::side_t side;
        logic [33:0]    rem;
        logic [31:0]    root;
        logic [63:0]    rad;
    } sq_t;

    logic [NQ-1:0] valid_reg;
    logic [NQ-1:0] en;
    sq_t           init;
    sq_t           st_next [NQ];
    sq_t           st_reg [NQ];

    function automatic sq_t sq_step(input sq_t s);
        sq_t         r;
        logic [35:0] sh;
        logic [35:0] tr;
        r  = s;
        sh = {s.rem, s.rad[63:62]};
        tr = {2'b00, s.root, 2'b01};
        if (sh >= tr)
        begin
            r.rem  = 34'(sh - tr);
            r.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            r.rem  = sh[33:0];
            r.root = {s.root[30:0], 1'b0};
        end
        r.rad = {s.rad[61:0], 2'b00};
        return r;
    endfunction

    always_comb
    begin
        en[NQ-1] = !valid_reg[NQ-1] || dn_ready;
        for (int i = NQ - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        init.side  = up_data;
        init.rem   = '0;
        init.root  = '0;
        init.rad   = up_rad;
        st_next[0] = sq_step(init);
        for (int j = 1; j < NQ; j++)
        begin
            st_next[j] = sq_step(st_reg[j-1]);
        end
    end

    assign up_ready = en[0];
    assign dn_valid = valid_reg[NQ-1];
    assign dn_data  = st_reg[NQ-1].side;
    assign dn_root  = st_reg[NQ-1].root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= up_valid;
            end
            for (int i = 1; i < NQ; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NQ; j++)
        begin
            if (en[j])
            begin
                st_reg[j] <= st_next[j];
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/v3a_div.sv
// Pipelined restoring divide for normalize, length scaling and result assembly.
`default_nettype none

module v3a_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  v3a_pkg::side_t     up_data,
    input  logic [31:0]        up_root,
    output logic               dn_valid,
    input  logic               dn_ready,
    output v3a_pkg::out_beat_t dn_data
);

    // quotient bits: a unit vector component never exceeds 2^16 + 1
    localparam int QW = 18;
    localparam int NS = QW + 2;

    typedef struct packed {
        v3a_pkg::side_t     side;
        logic [31:0]        l2;
        logic [31:0]        len;
        logic               lsat;
        logic [2:0][31:0]   rem;
        logic [2:0][QW-1:0] low;
        logic [2:0][QW-1:0] quo;
    } dv_t;

    logic [NS-1:0]      valid_reg;
    logic [NS-1:0]      en;
    dv_t                st_next [QW+1];
    dv_t                st_reg [QW+1];
    dv_t                fin;
    logic [31:0]        qv [3];
    logic [31:0]        rv [3];
    v3a_pkg::out_beat_t out_next;
    v3a_pkg::out_beat_t out_reg;

    function automatic dv_t dv_prep(input v3a_pkg::side_t sd, input logic [31:0] root);
        dv_t         r;
        logic [78:0] num;
        logic [5:0]  sh;
        logic [31:0] ln;
        sh     = 6'd16 + 6'(sd.k);
        ln     = root >> sd.k;
        r.side = sd;
        r.l2   = root;
        r.lsat = ln[31];
        r.len  = ln[31] ? v3a_pkg::Q_MAX : ln;
        for (int i = 0; i < 3; i++)
        begin
            num      = 79'(sd.mag[i]) << sh;
            r.rem[i] = num[QW+31:QW];
            r.low[i] = num[QW-1:0];
            r.quo[i] = '0;
        end
        return r;
    endfunction

    function automatic dv_t dv_step(input dv_t s);
        dv_t         r;
        logic [32:0] t;
        r = s;
        for (int i = 0; i < 3; i++)
        begin
            t = {s.rem[i], s.low[i][QW-1]};
            if (t >= {1'b0, s.l2})
            begin
                r.rem[i] = 32'(t - {1'b0, s.l2});
                r.quo[i] = {s.quo[i][QW-2:0], 1'b1};
            end
            else
            begin
                r.rem[i] = t[31:0];
                r.quo[i] = {s.quo[i][QW-2:0], 1'b0};
            end
            r.low[i] = {s.low[i][QW-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || dn_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        st_next[0] = dv_prep(up_data, up_root);
        for (int j = 1; j <= QW; j++)
        begin
            st_next[j] = dv_step(st_reg[j-1]);
        end
    end

    assign fin = st_reg[QW];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qv[i] = 32'(fin.quo[i]);
            rv[i] = fin.side.neg[i] ? (~qv[i] + 32'd1) : qv[i];
        end
        out_next = '0;
        unique case (fin.side.op)
            v3a_pkg::OP_NORMALIZE:
            begin
                if (fin.side.zero)
                begin
                    out_next.zero_length = 1'b1;
                end
                else
                begin
                    out_next.r_x = $signed(rv[0]);
                    out_next.r_y = $signed(rv[1]);
                    out_next.r_z = $signed(rv[2]);
                end
            end
            v3a_pkg::OP_LENGTH:
            begin
                out_next.r_x       = $signed(fin.len);
                out_next.saturated = fin.lsat;
            end
            default:
            begin
                out_next.r_x       = $signed(fin.side.res[0]);
                out_next.r_y       = $signed(fin.side.res[1]);
                out_next.r_z       = $signed(fin.side.res[2]);
                out_next.saturated = fin.side.sat;
            end
        endcase
    end

    assign up_ready = en[0];
    assign dn_valid = valid_reg[NS-1];
    assign dn_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= up_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= QW; j++)
        begin
            if (en[j])
            begin
                st_reg[j] <= st_next[j];
            end
        end
        if (en[NS-1])
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vector3_alu_unit.sv
// Top level of the Q16.16 three-component vector ALU.
//
//   port      dir   beat contents
//   operand   sink  op, a_x..a_z, b_x..b_z, scale
//   result    src   r_x, r_y, r_z, saturated, zero_length
//
// Every opcode takes the same path: 7 arithmetic stages, 32 root
// stages (one root bit each) and 20 divide and assembly stages.
// One beat is accepted per cycle unless a stalled result has filled the stages; beats leave in order.
// rst_n clears the valid bits only; data registers hold whatever they had.
// A stalled result holds its stage; earlier empty stages keep filling.
`default_nettype none

module vector3_alu_unit (
    input  logic       clk,
    input  logic       rst_n,
    v3a_in_if.sink     operand,
    v3a_out_if.source  result
);

    logic           ar_valid;
    logic           ar_ready;
    v3a_pkg::side_t ar_data;
    logic [63:0]    ar_rad;

    logic           sq_valid;
    logic           sq_ready;
    v3a_pkg::side_t sq_data;
    logic [31:0]    sq_root;

    logic           op_ready;
    logic           dv_valid;
    v3a_pkg::out_beat_t dv_data;

    v3a_arith u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (operand.valid),
        .up_ready (op_ready),
        .up_data  (operand.data),
        .dn_valid (ar_valid),
        .dn_ready (ar_ready),
        .dn_data  (ar_data),
        .dn_rad   (ar_rad)
    );

    v3a_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (ar_valid),
        .up_ready (ar_ready),
        .up_data  (ar_data),
        .up_rad   (ar_rad),
        .dn_valid (sq_valid),
        .dn_ready (sq_ready),
        .dn_data  (sq_data),
        .dn_root  (sq_root)
    );

    v3a_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sq_valid),
        .up_ready (sq_ready),
        .up_data  (sq_data),
        .up_root  (sq_root),
        .dn_valid (dv_valid),
        .dn_ready (result.ready),
        .dn_data  (dv_data)
    );

    assign operand.ready = op_ready;
    assign result.valid  = dv_valid;
    assign result.data   = dv_data;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for vector3_alu_unit: random and directed operand beats checked against a predictor.
`default_nettype none

module tb;

    typedef logic signed [127:0] wide_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 1600;

    logic clk;
    logic rst_n;

    v3a_in_if  op_ch ();
    v3a_out_if res_ch ();

    vector3_alu_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (op_ch),
        .result  (res_ch)
    );

    v3a_pkg::in_beat_t  pending_ops[$];
    v3a_pkg::out_beat_t expected_results[$];
    int                 error_count;
    int                 idle_cycles;
    int                 send_gap;
    int                 recv_stall;
    bit                 bursty;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic wide_t round_q16(input wide_t x);
        return (x + 128'sd32768) >>> 16;
    endfunction

    function automatic logic [32:0] clamp_q16(input wide_t v);
        if (v > 128'sd2147483647)
        begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        if (v < -128'sd2147483648)
        begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [127:0] root_floor(input logic [127:0] n);
        logic [127:0] rem;
        logic [127:0] res;
        logic [127:0] one_bit;
        rem = n;
        res = '0;
        one_bit = 128'd1 << 126;
        while (one_bit > rem)
        begin
            one_bit = one_bit >> 2;
        end
        while (one_bit != 0)
        begin
            if (rem >= res + one_bit)
            begin
                rem = rem - (res + one_bit);
                res = (res >> 1) + one_bit;
            end
            else
            begin
                res = res >> 1;
            end
            one_bit = one_bit >> 2;
        end
        return res;
    endfunction

    function automatic v3a_pkg::out_beat_t predict_vector(input v3a_pkg::in_beat_t beat);
        v3a_pkg::out_beat_t res;
        wide_t      a[3];
        wide_t      b[3];
        wide_t      r[3];
        wide_t      t;
        wide_t      d;
        wide_t      dh;
        wide_t      dl;
        wide_t      m;
        logic [127:0] sq;
        logic [127:0] l2;
        logic [127:0] q;
        logic [127:0] mg;
        logic [32:0] c;
        int          k;
        bit          sat;
        bit          zl;
        a[0] = wide_t'(beat.a_x);
        a[1] = wide_t'(beat.a_y);
        a[2] = wide_t'(beat.a_z);
        b[0] = wide_t'(beat.b_x);
        b[1] = wide_t'(beat.b_y);
        b[2] = wide_t'(beat.b_z);
        t = wide_t'(beat.scale);
        sat = 0;
        zl = 0;
        for (int i = 0; i < 3; i++)
        begin
            r[i] = '0;
        end
        case (beat.op)
            v3a_pkg::OP_ADD:
            begin
                for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            end
            v3a_pkg::OP_SUB:
            begin
                for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            end
            v3a_pkg::OP_SCALE:
            begin
                for (int i = 0; i < 3; i++) r[i] = round_q16(a[i] * t);
            end
            v3a_pkg::OP_DOT:
            begin
                r[0] = round_q16(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
            end
            v3a_pkg::OP_LENGTH, v3a_pkg::OP_NORMALIZE:
            begin
                sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                if (beat.op == v3a_pkg::OP_LENGTH)
                begin
                    r[0] = root_floor(sq);
                end
                else if (sq == 0)
                begin
                    zl = 1;
                end
                else
                begin
                    k = 0;
                    while ((sq >> 62) == 0)
                    begin
                        sq = sq << 2;
                        k++;
                    end
                    l2 = root_floor(sq);
                    for (int i = 0; i < 3; i++)
                    begin
                        mg = (a[i] < 0) ? -a[i] : a[i];
                        q = (mg << (16 + k)) / l2;
                        r[i] = (a[i] < 0) ? -wide_t'(q) : wide_t'(q);
                    end
                end
            end
            v3a_pkg::OP_CROSS:
            begin
                r[0] = round_q16(a[1] * b[2] - a[2] * b[1]);
                r[1] = round_q16(a[2] * b[0] - a[0] * b[2]);
                r[2] = round_q16(a[0] * b[1] - a[1] * b[0]);
            end
            v3a_pkg::OP_LERP:
            begin
                for (int i = 0; i < 3; i++) r[i] = round_q16((b[i] - a[i]) * t + (a[i] <<< 16));
            end
            v3a_pkg::OP_REFLECT:
            begin
                d = round_q16(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
                dh = d >>> 16;
                dl = d - (dh <<< 16);
                for (int i = 0; i < 3; i++)
                begin
                    m = dh * b[i];
                    // hold the product at the reflect limit, sign kept
                    if (m > (128'sd1 <<< 40)) m = 128'sd1 <<< 40;
                    if (m < -(128'sd1 <<< 40)) m = -(128'sd1 <<< 40);
                    r[i] = a[i] - 2 * m + ((128'sd32768 - 2 * dl * b[i]) >>> 16);
                end
            end
            default:
            begin
            end
        endcase
        c = clamp_q16(r[0]);
        res.r_x = c[31:0];
        sat |= c[32];
        c = clamp_q16(r[1]);
        res.r_y = c[31:0];
        sat |= c[32];
        c = clamp_q16(r[2]);
        res.r_z = c[31:0];
        sat |= c[32];
        res.saturated = sat;
        res.zero_length = zl;
        return res;
    endfunction

    function automatic int draw_wait();
        if (bursty)
        begin
            return 0;
        end
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
    endfunction

    function automatic logic [31:0] rand_q16();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2, 3: v = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            4: v = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'h0001_0000;
                    4: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_8000;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic queue_op(input logic [3:0] op, input logic [31:0] ax, input logic [31:0] ay,
                            input logic [31:0] az, input logic [31:0] bx, input logic [31:0] by,
                            input logic [31:0] bz, input logic [31:0] t);
        v3a_pkg::in_beat_t beat;
        beat.op = op;
        beat.a_x = ax;
        beat.a_y = ay;
        beat.a_z = az;
        beat.b_x = bx;
        beat.b_y = by;
        beat.b_z = bz;
        beat.scale = t;
        pending_ops.push_back(beat);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (op_ch.valid && op_ch.ready)
            begin
                expected_results.push_back(predict_vector(op_ch.data));
            end
            if (!op_ch.valid || op_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    op_ch.valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    op_ch.data <= pending_ops.pop_front();
                    op_ch.valid <= 1'b1;
                    send_gap <= draw_wait();
                    if ($urandom_range(0, 63) == 0) bursty = ~bursty;
                end
                else
                begin
                    op_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        v3a_pkg::out_beat_t want;
        int                 stall;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_stall <= 0;
        end
        else if (res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report("unexpected beat", res_ch.data.r_x, 32'h0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.data.r_x !== want.r_x) report("r_x", res_ch.data.r_x, want.r_x);
                if (res_ch.data.r_y !== want.r_y) report("r_y", res_ch.data.r_y, want.r_y);
                if (res_ch.data.r_z !== want.r_z) report("r_z", res_ch.data.r_z, want.r_z);
                if (res_ch.data.saturated !== want.saturated)
                    report("saturated", 32'(res_ch.data.saturated), 32'(want.saturated));
                if (res_ch.data.zero_length !== want.zero_length)
                    report("zero_length", 32'(res_ch.data.zero_length),
                           32'(want.zero_length));
            end
            stall = draw_wait();
            recv_stall <= stall;
            res_ch.ready <= (stall == 0);
        end
        else if (!res_ch.ready)
        begin
            if (recv_stall <= 1)
            begin
                recv_stall <= 0;
                res_ch.ready <= 1'b1;
            end
            else
            begin
                recv_stall <= recv_stall - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        op_ch.valid = 1'b0;
        op_ch.data = '0;
        res_ch.ready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        bursty = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, rounding ties, zero vector, undefined opcodes
        queue_op(v3a_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h0);
        queue_op(v3a_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0003, 32'hFFFF_FFFF);
        queue_op(v3a_pkg::OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
        queue_op(v3a_pkg::OP_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003,
                 32'h0, 32'h0, 32'h0, 32'h0000_8000);
        queue_op(v3a_pkg::OP_SCALE, 32'h0002_0000, 32'hFFFE_8000, 32'h8000_0000,
                 32'h0, 32'h0, 32'h0, 32'h8000_0000);
        queue_op(v3a_pkg::OP_DOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        queue_op(v3a_pkg::OP_DOT, 32'h0000_0001, 32'h0000_0001, 32'h0,
                 32'h0000_8000, 32'hFFFF_8000, 32'h0, 32'h0);
        queue_op(v3a_pkg::OP_LENGTH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h0, 32'h0, 32'h0, 32'h0);
        queue_op(v3a_pkg::OP_LENGTH, 32'h0003_0000, 32'h0004_0000, 32'h0,
                 32'h0, 32'h0, 32'h0, 32'h0);
        queue_op(v3a_pkg::OP_NORMALIZE, 32'h0, 32'h0, 32'h0,
                 32'h7FFF_FFFF, 32'h1, 32'h1, 32'h1);
        queue_op(v3a_pkg::OP_NORMALIZE, 32'h0003_0000, 32'hFFFC_0000, 32'h0,
                 32'h0, 32'h0, 32'h0, 32'h0);
        queue_op(v3a_pkg::OP_NORMALIZE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h0, 32'h0, 32'h0, 32'h0);
        queue_op(v3a_pkg::OP_NORMALIZE, 32'h0000_0001, 32'h0, 32'h0,
                 32'h0, 32'h0, 32'h0, 32'h0);
        queue_op(v3a_pkg::OP_NORMALIZE, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h0, 32'h0, 32'h0, 32'h0);
        queue_op(v3a_pkg::OP_CROSS, 32'h0001_0000, 32'h0, 32'h0,
                 32'h0, 32'h0001_0000, 32'h0, 32'h0);
        queue_op(v3a_pkg::OP_CROSS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        queue_op(v3a_pkg::OP_LERP, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        queue_op(v3a_pkg::OP_LERP, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        queue_op(v3a_pkg::OP_LERP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0002, 32'h8000_0000);
        queue_op(v3a_pkg::OP_REFLECT, 32'h0001_0000, 32'hFFFF_0000, 32'h0,
                 32'h0, 32'h0001_0000, 32'h0, 32'h0);
        queue_op(v3a_pkg::OP_REFLECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        queue_op(v3a_pkg::OP_REFLECT, 32'h0000_0003, 32'h0, 32'h0,
                 32'h0000_8000, 32'h0, 32'h0, 32'h0);
        queue_op(4'd9, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // hold the sender until the directed beats have all drained
        while (pending_ops.size() > 0 || op_ch.valid || expected_results.size() > 0)
        begin
            @(posedge clk);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            queue_op(($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8)),
                     rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                     rand_q16());
        end

        while (pending_ops.size() > 0 || op_ch.valid || expected_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
